FILE: hdl/vec3_ray_optics_alu_macros.svh
// ----------------------------------------------------------------------------
// vec3_ray_optics_alu_macros
// Assertion macros for the vector optics unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef VEC3_RAY_OPTICS_ALU_MACROS_SVH
`define VEC3_RAY_OPTICS_ALU_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VRO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");
// next-cycle implication
`define VRO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");
`else
`define VRO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VRO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/vro_pkg.sv
// ----------------------------------------------------------------------------
// vro_pkg
// Types, constants and saturation helpers of the vector optics unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vro_pkg;

    // word format: signed Q16.16
    localparam int DW      = 32;
    localparam int FB      = 16;
    localparam int LW      = DW - 1;
    localparam int PW      = 2 * DW;
    localparam int SW      = PW + 16;
    // square root of a 48-bit radicand, two result bits per step
    localparam int XW      = DW + FB;
    localparam int RB      = XW / 2;
    localparam int REMW    = RB + 4;
    localparam int SQ_ITER = 2;
    localparam int NSQ     = RB / SQ_ITER;

    // pipeline stage map
    localparam int ST_SQ0  = 12;
    localparam int ST_RM   = ST_SQ0 + NSQ;
    localparam int NSTG    = ST_RM + 2;
    localparam int LAST    = NSTG - 1;

    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_SCALE,
        CMD_CROSS,
        CMD_LEN,
        CMD_REFLECT,
        CMD_REFRACT
    } t_cmd;

    typedef logic signed [DW-1:0] t_word;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_wide;

    localparam t_word ONE_Q   = t_word'(1 << FB);
    localparam t_wide SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam t_wide SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_sat;

    // one item as it travels down the pipeline
    typedef struct packed {
        t_cmd               cmd;
        logic               ovf;
        t_word [2:0]        u;
        t_word [2:0]        v;
        t_word              s;
        t_word [2:0]        res;
        t_word              d;
        logic [LW-1:0]      ls;
        t_prod [2:0]        prd;
        t_prod [2:0]        pra;
        t_prod [2:0]        prb;
        logic [XW-1:0]      x;
        logic [RB-1:0]      root;
        logic [REMW-1:0]    rem;
    } t_item;

    function automatic t_wide wide_w(input t_word a);
        return t_wide'(a);
    endfunction

    function automatic t_wide wide_p(input t_prod a);
        return t_wide'(a);
    endfunction

    function automatic t_prod mul_ww(input t_word a, input t_word b);
        t_prod r;
        r = a * b;
        return r;
    endfunction

    // clamp a wide value to the word range and flag the clamp
    function automatic t_sat sat_word(input t_wide a);
        t_sat r;
        r.val = a[DW-1:0];
        r.ovf = 1'b0;
        if (a > SAT_MAX) begin
            r.val = SAT_MAX[DW-1:0];
            r.ovf = 1'b1;
        end else if (a < SAT_MIN) begin
            r.val = SAT_MIN[DW-1:0];
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vec3_ray_optics_alu.sv
// ----------------------------------------------------------------------------
// vec3_ray_optics_alu: Q16.16 vector add/sub/mul/scale/cross/length/reflect/refract
// Fully pipelined: one item per cycle sustained while the result is not stalled.
// Refraction sets the depth: dot, clamp, three multiplies, a 12-stage root, a multiply, a subtract.
// A stalled result freezes the whole pipeline; synchronous reset clears valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vec3_ray_optics_alu_macros.svh"

module vec3_ray_optics_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_command,
    input  logic signed [vro_pkg::DW-1:0] i_u_x,
    input  logic signed [vro_pkg::DW-1:0] i_u_y,
    input  logic signed [vro_pkg::DW-1:0] i_u_z,
    input  logic signed [vro_pkg::DW-1:0] i_v_x,
    input  logic signed [vro_pkg::DW-1:0] i_v_y,
    input  logic signed [vro_pkg::DW-1:0] i_v_z,
    input  logic signed [vro_pkg::DW-1:0] i_scalar_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [vro_pkg::DW-1:0] o_res_x,
    output logic signed [vro_pkg::DW-1:0] o_res_y,
    output logic signed [vro_pkg::DW-1:0] o_res_z,
    output logic [vro_pkg::LW-1:0]     o_len_sq,
    output logic                       o_overflow
);
    import vro_pkg::*;

    logic [NSTG-1:0] r_vld;
    t_item           r_pipe [NSTG];
    t_item           n_pipe [NSTG];
    logic            w_en;
    logic [REMW-1:0] w_sq_rem  [NSQ];
    logic [RB-1:0]   w_sq_root [NSQ];

    // advance unless a finished result is held back
    assign w_en    = !r_vld[LAST] || !i_stall;
    assign o_stall = !w_en;

    // square root steps
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        vro_sqrt_step u_step (
            .i_rem  (r_pipe[ST_SQ0+g-1].rem),
            .i_root (r_pipe[ST_SQ0+g-1].root),
            .i_bits (r_pipe[ST_SQ0+g-1].x[XW-1-2*SQ_ITER*g -: 2*SQ_ITER]),
            .o_rem  (w_sq_rem[g]),
            .o_root (w_sq_root[g])
        );
    end

    // stage logic
    always_comb begin
        t_sat               sr;
        t_wide              tw;
        t_word              opa;
        logic signed [RB:0] rs;

        for (int k = 1; k < NSTG; k++) begin
            n_pipe[k] = r_pipe[k-1];
        end

        // capture operands, add and subtract
        n_pipe[0]      = '0;
        n_pipe[0].cmd  = t_cmd'(i_command);
        n_pipe[0].u[0] = i_u_x;
        n_pipe[0].u[1] = i_u_y;
        n_pipe[0].u[2] = i_u_z;
        n_pipe[0].v[0] = i_v_x;
        n_pipe[0].v[1] = i_v_y;
        n_pipe[0].v[2] = i_v_z;
        n_pipe[0].s    = i_scalar_in;
        for (int i = 0; i < 3; i++) begin
            tw = '0;
            if (n_pipe[0].cmd == CMD_ADD) begin
                tw = wide_w(n_pipe[0].u[i]) + wide_w(n_pipe[0].v[i]);
            end else if (n_pipe[0].cmd == CMD_SUB) begin
                tw = wide_w(n_pipe[0].u[i]) - wide_w(n_pipe[0].v[i]);
            end
            sr = sat_word(tw);
            n_pipe[0].res[i] = sr.val;
            n_pipe[0].ovf    = n_pipe[0].ovf | sr.ovf;
        end

        // first products: elementwise, scale, dot terms and cross terms
        for (int i = 0; i < 3; i++) begin
            if (r_pipe[0].cmd == CMD_LEN) begin
                opa = r_pipe[0].v[i];
            end else if (r_pipe[0].cmd == CMD_SCALE) begin
                opa = r_pipe[0].s;
            end else begin
                opa = r_pipe[0].u[i];
            end
            n_pipe[1].prd[i] = mul_ww(opa, r_pipe[0].v[i]);
            n_pipe[1].pra[i] = mul_ww(r_pipe[0].u[(i+1)%3], r_pipe[0].v[(i+2)%3]);
            n_pipe[1].prb[i] = mul_ww(r_pipe[0].u[(i+2)%3], r_pipe[0].v[(i+1)%3]);
        end

        // rescale products, form dot product
        case (r_pipe[1].cmd)
            CMD_MUL, CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    sr = sat_word(wide_p(r_pipe[1].prd[i]) >>> FB);
                    n_pipe[2].res[i] = sr.val;
                    n_pipe[2].ovf    = n_pipe[2].ovf | sr.ovf;
                end
            end
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    sr = sat_word((wide_p(r_pipe[1].pra[i]) - wide_p(r_pipe[1].prb[i])) >>> FB);
                    n_pipe[2].res[i] = sr.val;
                    n_pipe[2].ovf    = n_pipe[2].ovf | sr.ovf;
                end
            end
            CMD_LEN, CMD_REFLECT, CMD_REFRACT: begin
                tw = (wide_p(r_pipe[1].prd[0]) + wide_p(r_pipe[1].prd[1])
                      + wide_p(r_pipe[1].prd[2])) >>> FB;
                sr = sat_word(tw);
                n_pipe[2].d   = sr.val;
                n_pipe[2].ovf = r_pipe[1].ovf | sr.ovf;
                if (r_pipe[1].cmd == CMD_LEN) begin
                    n_pipe[2].ls = sr.val[DW-1] ? '0 : sr.val[LW-1:0];
                end
            end
            default: begin
            end
        endcase

        // refraction cosine: negate the dot, clamp at one
        if (r_pipe[2].cmd == CMD_REFRACT) begin
            tw = -wide_w(r_pipe[2].d);
            if (tw > wide_w(ONE_Q)) begin
                n_pipe[3].d = ONE_Q;
            end else begin
                n_pipe[3].d = tw[DW-1:0];
            end
        end

        // scale normal by dot or cosine
        for (int i = 0; i < 3; i++) begin
            n_pipe[4].prd[i] = mul_ww(r_pipe[3].d, r_pipe[3].u[i]);
        end

        // reflect result, or perpendicular part before index scaling
        for (int i = 0; i < 3; i++) begin
            if (r_pipe[4].cmd == CMD_REFLECT) begin
                tw = -(wide_p(r_pipe[4].prd[i]) <<< 1);
                tw = (tw >>> FB) + wide_w(r_pipe[4].v[i]);
                sr = sat_word(tw);
                n_pipe[5].res[i] = sr.val;
                n_pipe[5].ovf    = n_pipe[5].ovf | sr.ovf;
            end else if (r_pipe[4].cmd == CMD_REFRACT) begin
                tw = wide_w(r_pipe[4].v[i]) + (wide_p(r_pipe[4].prd[i]) >>> FB);
                sr = sat_word(tw);
                n_pipe[5].res[i] = sr.val;
                n_pipe[5].ovf    = n_pipe[5].ovf | sr.ovf;
            end
        end

        // scale by index ratio
        if (r_pipe[5].cmd == CMD_REFRACT) begin
            for (int i = 0; i < 3; i++) begin
                n_pipe[6].prd[i] = mul_ww(r_pipe[5].res[i], r_pipe[5].s);
            end
        end

        // rescale perpendicular part
        if (r_pipe[6].cmd == CMD_REFRACT) begin
            for (int i = 0; i < 3; i++) begin
                sr = sat_word(wide_p(r_pipe[6].prd[i]) >>> FB);
                n_pipe[7].res[i] = sr.val;
                n_pipe[7].ovf    = n_pipe[7].ovf | sr.ovf;
            end
        end

        // square the perpendicular part
        if (r_pipe[7].cmd == CMD_REFRACT) begin
            for (int i = 0; i < 3; i++) begin
                n_pipe[8].prd[i] = mul_ww(r_pipe[7].res[i], r_pipe[7].res[i]);
            end
        end

        // its squared length
        if (r_pipe[8].cmd == CMD_REFRACT) begin
            tw = (wide_p(r_pipe[8].prd[0]) + wide_p(r_pipe[8].prd[1])
                  + wide_p(r_pipe[8].prd[2])) >>> FB;
            n_pipe[9].prd[0] = tw[PW-1:0];
        end

        // one minus squared length
        if (r_pipe[9].cmd == CMD_REFRACT) begin
            n_pipe[10].prd[0] = t_prod'(ONE_Q) - r_pipe[9].prd[0];
        end

        // magnitude, clamp, align as root radicand
        if (r_pipe[10].cmd == CMD_REFRACT) begin
            tw = wide_p(r_pipe[10].prd[0]);
            if (tw < 0) begin
                tw = -tw;
            end
            sr = sat_word(tw);
            n_pipe[11].ovf  = r_pipe[10].ovf | sr.ovf;
            n_pipe[11].x    = {1'b0, sr.val[DW-2:0], {FB{1'b0}}};
            n_pipe[11].rem  = '0;
            n_pipe[11].root = '0;
        end

        // root iterations
        for (int k = 0; k < NSQ; k++) begin
            n_pipe[ST_SQ0+k].rem  = w_sq_rem[k];
            n_pipe[ST_SQ0+k].root = w_sq_root[k];
        end

        // scale normal by root
        rs = {1'b0, r_pipe[ST_RM-1].root};
        for (int i = 0; i < 3; i++) begin
            n_pipe[ST_RM].prd[i] = rs * r_pipe[ST_RM-1].u[i];
        end

        // subtract root part from perpendicular part
        if (r_pipe[ST_RM].cmd == CMD_REFRACT) begin
            for (int i = 0; i < 3; i++) begin
                tw = ((-wide_p(r_pipe[ST_RM].prd[i])) >>> FB) + wide_w(r_pipe[ST_RM].res[i]);
                sr = sat_word(tw);
                n_pipe[ST_RM+1].res[i] = sr.val;
                n_pipe[ST_RM+1].ovf    = n_pipe[ST_RM+1].ovf | sr.ovf;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid    = r_vld[LAST];
    assign o_res_x    = r_pipe[LAST].res[0];
    assign o_res_y    = r_pipe[LAST].res[1];
    assign o_res_z    = r_pipe[LAST].res[2];
    assign o_len_sq   = r_pipe[LAST].ls;
    assign o_overflow = r_pipe[LAST].ovf;

    `VRO_ASSERT_IMP(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid)
    `VRO_ASSERT_NXT(a_stall_freezes_valids, i_clk, i_rst_n, o_stall, r_vld == $past(r_vld))
    `VRO_ASSERT_IMP(a_len_only_for_len, i_clk, i_rst_n,
        o_valid && r_pipe[LAST].cmd != CMD_LEN, o_len_sq == '0)
    `VRO_ASSERT_IMP(a_len_has_no_vector, i_clk, i_rst_n,
        o_valid && r_pipe[LAST].cmd == CMD_LEN,
        o_res_x == '0 && o_res_y == '0 && o_res_z == '0)

endmodule

`default_nettype wire

FILE: hdl/vro_sqrt_step.sv
// ----------------------------------------------------------------------------
// vro_sqrt_step
// Two digit-by-digit iterations of the integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vro_sqrt_step (
    input  logic [vro_pkg::REMW-1:0]      i_rem,
    input  logic [vro_pkg::RB-1:0]        i_root,
    input  logic [2*vro_pkg::SQ_ITER-1:0] i_bits,
    output logic [vro_pkg::REMW-1:0]      o_rem,
    output logic [vro_pkg::RB-1:0]        o_root
);
    import vro_pkg::*;

    // bring down a bit pair, try the next root bit, keep it if it fits
    always_comb begin
        logic [REMW-1:0] rem;
        logic [REMW-1:0] rw;
        logic [REMW-1:0] trial;
        logic [RB-1:0]   root;
        rem  = i_rem;
        root = i_root;
        for (int t = 0; t < SQ_ITER; t++) begin
            rw    = {rem[REMW-3:0], i_bits[2*(SQ_ITER-1-t) +: 2]};
            trial = {{(REMW-RB-2){1'b0}}, root, 2'b01};
            if (rw >= trial) begin
                rem  = rw - trial;
                root = {root[RB-2:0], 1'b1};
            end else begin
                rem  = rw;
                root = {root[RB-2:0], 1'b0};
            end
        end
        o_rem  = rem;
        o_root = root;
    end

endmodule

`default_nettype wire
